### rtl/s9bp_pkg.sv
package s9bp_pkg;

  localparam int BUFFER_DEPTH = 28;
  localparam int VALUE_W      = 8;
  localparam int MODE_W       = 4;
  localparam int WIDTH_W      = 5;
  localparam int WORD_W       = 32;
  localparam int PAYLOAD_W    = 28;
  localparam int SHIFT_W      = 10;

  localparam logic [MODE_W-1:0] MODE_BASE = 4'd0;
  localparam logic [MODE_W-1:0] MODE_TOP  = 4'd8;

  // bits per value in each mode
  function automatic logic [WIDTH_W-1:0] mode_width(input logic [MODE_W-1:0] mode);
    logic [WIDTH_W-1:0] w;
    unique case (mode)
      4'd0:    w = 5'd1;
      4'd1:    w = 5'd2;
      4'd2:    w = 5'd3;
      4'd3:    w = 5'd4;
      4'd4:    w = 5'd5;
      4'd5:    w = 5'd7;
      4'd6:    w = 5'd8;
      4'd7:    w = 5'd14;
      default: w = 5'd28;
    endcase
    return w;
  endfunction

  // values per word in each mode
  function automatic logic [WIDTH_W-1:0] mode_capacity(input logic [MODE_W-1:0] mode);
    logic [WIDTH_W-1:0] c;
    unique case (mode)
      4'd0:    c = 5'd28;
      4'd1:    c = 5'd12;
      4'd2:    c = 5'd9;
      4'd3:    c = 5'd7;
      4'd4:    c = 5'd5;
      4'd5:    c = 5'd4;
      4'd6:    c = 5'd3;
      4'd7:    c = 5'd2;
      default: c = 5'd1;
    endcase
    return c;
  endfunction

  // smallest mode whose field holds the byte
  function automatic logic [MODE_W-1:0] value_mode(input logic [VALUE_W-1:0] v);
    logic [MODE_W-1:0] m;
    priority if (v <= 8'd1)   m = 4'd0;
    else if (v <= 8'd3)       m = 4'd1;
    else if (v <= 8'd7)       m = 4'd2;
    else if (v <= 8'd15)      m = 4'd3;
    else if (v <= 8'd31)      m = 4'd4;
    else if (v <= 8'd127)     m = 4'd5;
    else                      m = 4'd6;
    return m;
  endfunction

  // widest mode whose capacity still holds cnt values
  function automatic logic [MODE_W-1:0] fit_mode(input logic [7:0] cnt);
    logic [MODE_W-1:0] m;
    priority if (cnt <= 8'd1) m = 4'd8;
    else if (cnt <= 8'd2)     m = 4'd7;
    else if (cnt <= 8'd3)     m = 4'd6;
    else if (cnt <= 8'd4)     m = 4'd5;
    else if (cnt <= 8'd5)     m = 4'd4;
    else if (cnt <= 8'd7)     m = 4'd3;
    else if (cnt <= 8'd9)     m = 4'd2;
    else if (cnt <= 8'd12)    m = 4'd1;
    else                      m = 4'd0;
    return m;
  endfunction

  function automatic logic [MODE_W-1:0] max_mode(input logic [MODE_W-1:0] a,
                                                 input logic [MODE_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/s9bp_cell.sv
module s9bp_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                               clk,
  input  logic                               shift_en,
  input  logic [s9bp_pkg::VALUE_W-1:0]       shift_in,
  input  logic [s9bp_pkg::WIDTH_W-1:0]       width,
  input  logic [CNT_W-1:0]                   count,
  output logic [s9bp_pkg::VALUE_W-1:0]       value,
  output logic [s9bp_pkg::WORD_W-1:0]        contrib
);

  logic [s9bp_pkg::SHIFT_W-1:0] shamt;

  // newest byte sits in cell 0, older ones move up the chain
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value <= shift_in;
    end
  end

  // field offset of this cell counted from the low end of the packed values
  assign shamt = s9bp_pkg::SHIFT_W'(INDEX) * s9bp_pkg::SHIFT_W'(width);

  always_comb begin
    if (count > CNT_W'(INDEX)) begin
      contrib = s9bp_pkg::WORD_W'(value) << shamt;
    end else begin
      contrib = '0;
    end
  end

endmodule

### rtl/simple9_byte_packer_unit.sv
// Greedy Simple9 packer for a byte stream. Each request on the slave side carries one
// byte (tdata) and a last flag (tlast); the master side delivers 32-bit words with the
// 4-bit selector in bits 31..28 and the buffered bytes packed downward from bit 27 in
// arrival order, unused low bits zero, and tlast set on the word that closes the stream.
// Up to 28 bytes are held in a shift chain of byte cells, the newest at the bottom. A
// word goes out when the buffer is full for its mode, when a wider byte would no longer
// fit, and after the byte marked last; the selector is the widest mode whose capacity
// still holds the buffered count. A byte that needs no flush shifts into the chain when
// it is taken. A byte that forces a flush is first held; the word built from the chain
// is then loaded into the output register in the same cycle the held byte shifts in.
// After a last byte the closing word is loaded in a further step. A pending flush or
// closing word waits while the output register still holds an untaken word. After reset
// the block is ready at once and starts a new stream after each last byte.
module simple9_byte_packer_unit #(
  parameter int BUFFER_DEPTH = s9bp_pkg::BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] value
  input  logic        s_tlast,    // last_value
  // packed word stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] packed_word
  output logic        m_tlast     // last_word
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // taking bytes
  localparam logic [1:0] ST_FLUSH = 2'd1;  // old buffer out, held byte in
  localparam logic [1:0] ST_LAST  = 2'd2;  // closing word out

  logic [1:0]                         state;
  logic [CNT_W-1:0]                   count;
  logic [s9bp_pkg::MODE_W-1:0]        mode;
  logic [s9bp_pkg::VALUE_W-1:0]       held_value;
  logic                               held_last;
  logic [s9bp_pkg::MODE_W-1:0]        held_mode;
  logic                               out_valid;
  logic [s9bp_pkg::WORD_W-1:0]        out_word;
  logic                               out_last;

  logic                               in_accept;
  logic                               out_free;
  logic [s9bp_pkg::MODE_W-1:0]        in_mode;
  logic [s9bp_pkg::MODE_W-1:0]        grow_mode;
  logic [s9bp_pkg::MODE_W-1:0]        append_mode;
  logic                               buffer_full;
  logic                               flush_first;
  logic                               shift_en;
  logic [s9bp_pkg::VALUE_W-1:0]       shift_in;
  logic                               load_word;

  // word builder signals
  logic [s9bp_pkg::MODE_W-1:0]        word_mode;
  logic [s9bp_pkg::WIDTH_W-1:0]       word_width;
  logic [s9bp_pkg::SHIFT_W-1:0]       used_bits;
  logic [s9bp_pkg::SHIFT_W-1:0]       pad_bits;
  logic [s9bp_pkg::WORD_W-1:0]        fields;
  logic [s9bp_pkg::WORD_W-1:0]        aligned;
  logic [s9bp_pkg::WORD_W-1:0]        packed_word;

  logic [s9bp_pkg::VALUE_W-1:0]       chain [BUFFER_DEPTH+1];
  logic [s9bp_pkg::WORD_W-1:0]        cell_contrib [BUFFER_DEPTH];

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  // mode bookkeeping for the incoming byte
  assign in_mode     = s9bp_pkg::value_mode(s_tdata);
  assign grow_mode   = s9bp_pkg::max_mode(mode, in_mode);
  assign buffer_full = (count >= CNT_W'(s9bp_pkg::mode_capacity(mode)));
  // full buffer, or the wider mode has no room left for one more byte
  assign flush_first = (count >= CNT_W'(s9bp_pkg::mode_capacity(grow_mode)));
  // after a flush of a full buffer the mode restarts from the byte alone
  assign append_mode = buffer_full ? in_mode : grow_mode;

  always_comb begin
    shift_en  = 1'b0;
    load_word = 1'b0;
    unique case (state)
      ST_IDLE: begin
        shift_en = in_accept && !flush_first;
      end
      ST_FLUSH: begin
        shift_en  = out_free;
        load_word = out_free;
      end
      ST_LAST: begin
        load_word = out_free;
      end
      default: begin
        shift_en  = 1'b0;
        load_word = 1'b0;
      end
    endcase
  end

  assign shift_in = (state == ST_IDLE) ? s_tdata : held_value;
  assign chain[0] = shift_in;

  // chain of byte cells
  for (genvar j = 0; j < BUFFER_DEPTH; j++) begin : g_cell
    s9bp_cell #(
      .INDEX (j),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .shift_in (chain[j]),
      .width    (word_width),
      .count    (count),
      .value    (chain[j+1]),
      .contrib  (cell_contrib[j])
    );
  end

  // word builder: widest mode that holds the count, fields then padded to the top
  assign word_mode  = s9bp_pkg::max_mode(mode, s9bp_pkg::fit_mode(8'(count)));
  assign word_width = s9bp_pkg::mode_width(word_mode);
  assign used_bits  = s9bp_pkg::SHIFT_W'(count) * s9bp_pkg::SHIFT_W'(word_width);
  assign pad_bits   = s9bp_pkg::SHIFT_W'(s9bp_pkg::PAYLOAD_W) - used_bits;

  always_comb begin
    fields = '0;
    for (int j = 0; j < BUFFER_DEPTH; j++) begin
      fields = fields | cell_contrib[j];
    end
  end

  assign aligned     = fields << pad_bits;
  assign packed_word = {word_mode, aligned[s9bp_pkg::PAYLOAD_W-1:0]};

  // sequencer and buffer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      mode  <= s9bp_pkg::MODE_BASE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (flush_first) begin
              state <= ST_FLUSH;
            end else begin
              count <= count + CNT_W'(1);
              mode  <= append_mode;
              if (s_tlast) begin
                state <= ST_LAST;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            count <= CNT_W'(1);
            mode  <= held_mode;
            state <= held_last ? ST_LAST : ST_IDLE;
          end
        end
        ST_LAST: begin
          if (out_free) begin
            count <= '0;
            mode  <= s9bp_pkg::MODE_BASE;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // byte waiting behind a flush
  always_ff @(posedge clk) begin
    if (in_accept && flush_first) begin
      held_value <= s_tdata;
      held_last  <= s_tlast;
      held_mode  <= append_mode;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_word) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_word) begin
      out_word <= packed_word;
      out_last <= (state == ST_LAST);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_word;
  assign m_tlast  = out_last;

endmodule
